/* rtl/byte_rotor_stream_cipher_macros.svh */
// assertion macros shared by the byte rotor cipher rtl
// no dependencies; included by files that carry assertions
`ifndef BYTE_ROTOR_STREAM_CIPHER_MACROS_SVH
`define BYTE_ROTOR_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, held off during reset
`define BRSC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("brsc check failed");

// next-cycle implication, held off during reset
`define BRSC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("brsc check failed");

`endif

/* rtl/brsc_pkg.sv */
// shared types and constants of the byte rotor cipher
// no dependencies
package brsc_pkg;

  localparam int MAX_ROUNDS_DEF = 8;
  localparam int CFG_W          = 64;
  localparam int TBL_DEPTH      = 256;

  localparam logic [63:0] POS_STEP    = 64'h0103_0507_090b_0d0f;
  localparam logic [31:0] POS_STEP_LO = 32'h090b_0d0f;
  localparam logic [31:0] POS_STEP_HI = 32'h0103_0507;

  // request codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_SETPOS = 2'd1;
  localparam logic [1:0] ACT_CIPHER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DIR    = 2'd0;
  localparam logic [1:0] REG_ROUNDS = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  // round counts that transform
  localparam logic [3:0] RC_SHORT = 4'd3;
  localparam logic [3:0] RC_MID   = 4'd5;
  localparam logic [3:0] RC_FULL  = 4'd8;

  // request moving along the cell row; k carries the table index on writes
  typedef struct packed {
    logic       wr;
    logic       ciph;
    logic       dir;
    logic [7:0] k;
    logic [7:0] tval;
  } cell_req_t;

endpackage

/* rtl/brsc_pos.sv */
// position word unit: start position multiply, position register, key byte lanes
// depends on brsc_pkg
module brsc_pos #(
  parameter int NCELL = brsc_pkg::MAX_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_acc,
  input  logic [1:0]            action,
  input  logic [7:0]            tidx,
  input  logic [7:0]            tval,
  input  logic [63:0]           start_pos,
  input  logic [7:0]            data,
  input  logic                  dir,
  input  logic [3:0]            rounds,
  input  logic [63:0]           base,
  output brsc_pkg::cell_req_t   req_o,
  output logic [NCELL*8-1:0]    key_o,
  output logic [NCELL-1:0]      act_o
);

  logic        s1_wr_r, s1_set_r, s1_ciph_r;
  logic [7:0]  s1_a_r, s1_b_r;
  logic [63:0] pp0_r;
  logic [31:0] pp1_r, pp2_r;
  logic [63:0] pp0_nxt;
  logic [31:0] pp1_nxt, pp2_nxt;

  logic [63:0] pos_r, pos_nxt, pos_set;
  logic        wr_r, ciph_r;
  logic        dir_r;
  logic [7:0]  k_r, tval_r;
  logic [NCELL*8-1:0] key_r, key_nxt;
  logic [NCELL-1:0]   act_r, act_nxt;
  logic        rvalid;

  // start * step mod 2^64 as three 32x32 partial products
  assign pp0_nxt = 64'(start_pos[31:0]) * 64'(brsc_pkg::POS_STEP_LO);
  assign pp1_nxt = start_pos[31:0] * brsc_pkg::POS_STEP_HI;
  assign pp2_nxt = start_pos[63:32] * brsc_pkg::POS_STEP_LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_wr_r   <= 1'b0;
      s1_set_r  <= 1'b0;
      s1_ciph_r <= 1'b0;
    end else begin
      s1_wr_r   <= in_acc && (action == brsc_pkg::ACT_WRITE);
      s1_set_r  <= in_acc && (action == brsc_pkg::ACT_SETPOS);
      s1_ciph_r <= in_acc && (action == brsc_pkg::ACT_CIPHER);
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r <= (action == brsc_pkg::ACT_WRITE) ? tidx : data;
    s1_b_r <= tval;
    pp0_r  <= pp0_nxt;
    pp1_r  <= pp1_nxt;
    pp2_r  <= pp2_nxt;
  end

  assign pos_set = base + pp0_r + {pp1_r + pp2_r, 32'b0};

  always_comb begin
    if (s1_set_r) begin
      pos_nxt = pos_set;
    end else if (s1_ciph_r) begin
      pos_nxt = pos_r + brsc_pkg::POS_STEP;
    end else begin
      pos_nxt = pos_r;
    end
  end

  assign rvalid = ((rounds == brsc_pkg::RC_SHORT) || (rounds == brsc_pkg::RC_MID) ||
                   (rounds == brsc_pkg::RC_FULL)) && (rounds <= 4'(NCELL));

  // cell j uses byte j on decrypt and byte rounds-1-j on encrypt
  for (genvar j = 0; j < NCELL; j++) begin : g_key
    logic [2:0] src;
    assign src = dir ? 3'(j) : 3'(rounds - 4'd1 - 4'(j));
    assign key_nxt[j*8 +: 8] = pos_r[src*8 +: 8];
    assign act_nxt[j] = s1_ciph_r && rvalid && (4'(j) < rounds);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      wr_r   <= 1'b0;
      ciph_r <= 1'b0;
      act_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      wr_r   <= s1_wr_r;
      ciph_r <= s1_ciph_r;
      act_r  <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r  <= dir;
    k_r    <= s1_a_r;
    tval_r <= s1_b_r;
    key_r  <= key_nxt;
  end

  always_comb begin
    req_o.wr   = wr_r;
    req_o.ciph = ciph_r;
    req_o.dir  = dir_r;
    req_o.k    = k_r;
    req_o.tval = tval_r;
  end

  assign key_o = key_r;
  assign act_o = act_r;

endmodule

/* rtl/brsc_cell.sv */
// one rotor round: private copy of forward and inverse tables, one lookup per cycle
// depends on brsc_pkg
module brsc_cell #(
  parameter int NCELL    = brsc_pkg::MAX_ROUNDS_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  brsc_pkg::cell_req_t req_i,
  input  logic [NCELL*8-1:0]  key_i,
  input  logic [NCELL-1:0]    act_i,
  output brsc_pkg::cell_req_t req_o,
  output logic [NCELL*8-1:0]  key_o,
  output logic [NCELL-1:0]    act_o
);

  logic [7:0] fwd_mem [brsc_pkg::TBL_DEPTH];
  logic [7:0] inv_mem [brsc_pkg::TBL_DEPTH];

  logic       wr_r, ciph_r;
  logic [NCELL-1:0]   act_r;
  logic       dir_r;
  logic [7:0] k_r, tval_r, fq_r, iq_r;
  logic [NCELL*8-1:0] key_r;
  logic [7:0] rd_addr, kb, k_out;

  assign rd_addr = req_i.k + key_i[CELL_IDX*8 +: 8];

  // table writes ride the row so every copy changes in request order
  always_ff @(posedge clk) begin
    if (req_i.wr) begin
      fwd_mem[req_i.k]    <= req_i.tval;
      inv_mem[req_i.tval] <= req_i.k;
    end
    fq_r <= fwd_mem[rd_addr];
    iq_r <= inv_mem[req_i.k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      ciph_r <= 1'b0;
      act_r  <= '0;
    end else begin
      wr_r   <= req_i.wr;
      ciph_r <= req_i.ciph;
      act_r  <= act_i;
    end
  end

  always_ff @(posedge clk) begin
    dir_r  <= req_i.dir;
    k_r    <= req_i.k;
    tval_r <= req_i.tval;
    key_r  <= key_i;
  end

  assign kb = key_r[CELL_IDX*8 +: 8];

  always_comb begin
    if (!act_r[CELL_IDX]) begin
      k_out = k_r;
    end else if (dir_r) begin
      k_out = iq_r - kb;
    end else begin
      k_out = fq_r;
    end
  end

  always_comb begin
    req_o.wr   = wr_r;
    req_o.ciph = ciph_r;
    req_o.dir  = dir_r;
    req_o.k    = k_out;
    req_o.tval = tval_r;
  end

  assign key_o = key_r;
  assign act_o = act_r;

endmodule

/* rtl/brsc_fifo.sv */
// result queue between the cell row and the output channel
// depends on the assertion macro header
`include "byte_rotor_stream_cipher_macros.svh"

module brsc_fifo #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_en;

  assign out_valid = (cnt_r != '0);
  assign rd_en     = out_valid && !out_stall;
  assign out_data  = mem[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (rd_en) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= wr_data;
    end
  end

  `BRSC_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_en, cnt_r != CNT_W'(DEPTH))

endmodule

/* rtl/byte_rotor_stream_cipher.sv */
// byte rotor stream cipher top: config registers, position unit, row of round cells
// a cipher request's byte is registered through the position unit and every round cell, then queued until offered
// throughput: one request per cycle while in_stall is low, one read per table per round cell per cycle;
// in_stall rises only while every output queue slot is reserved by cipher requests
// reset: control, position word and config clear (round count 8); tables stay undefined
// depends on brsc_pkg, brsc_pos, brsc_cell, brsc_fifo and the macro header
`include "byte_rotor_stream_cipher_macros.svh"

module byte_rotor_stream_cipher #(
  parameter int MAX_ROUNDS = brsc_pkg::MAX_ROUNDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [7:0]                 in_table_index,
  input  logic [7:0]                 in_table_value,
  input  logic [63:0]                in_start_pos,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [brsc_pkg::CFG_W-1:0] cfg_data
);

  localparam int OQ_DEPTH = 2 ** $clog2(MAX_ROUNDS + 3);
  localparam int CRD_W    = $clog2(OQ_DEPTH + 1);

  logic        dir_r;
  logic [3:0]  rounds_r;
  logic [63:0] base_r;

  logic             in_acc, crd_inc, crd_dec;
  logic [CRD_W-1:0] crd_r;

  brsc_pkg::cell_req_t       chain_req [MAX_ROUNDS+1];
  logic [MAX_ROUNDS*8-1:0]   chain_key [MAX_ROUNDS+1];
  logic [MAX_ROUNDS-1:0]     chain_act [MAX_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      rounds_r <= brsc_pkg::RC_FULL;
      base_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        brsc_pkg::REG_DIR:    dir_r    <= cfg_data[0];
        brsc_pkg::REG_ROUNDS: rounds_r <= cfg_data[3:0];
        brsc_pkg::REG_BASE:   base_r   <= cfg_data[63:0];
        default: ;
      endcase
    end
  end

  // queue slots reserved per accepted cipher request
  assign in_stall = (crd_r == CRD_W'(OQ_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign crd_inc  = in_acc && (in_action == brsc_pkg::ACT_CIPHER);
  assign crd_dec  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crd_r <= '0;
    end else if (crd_inc && !crd_dec) begin
      crd_r <= crd_r + 1'b1;
    end else if (!crd_inc && crd_dec) begin
      crd_r <= crd_r - 1'b1;
    end
  end

  brsc_pos #(
    .NCELL (MAX_ROUNDS)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .action    (in_action),
    .tidx      (in_table_index),
    .tval      (in_table_value),
    .start_pos (in_start_pos),
    .data      (in_data_byte),
    .dir       (dir_r),
    .rounds    (rounds_r),
    .base      (base_r),
    .req_o     (chain_req[0]),
    .key_o     (chain_key[0]),
    .act_o     (chain_act[0])
  );

  for (genvar c = 0; c < MAX_ROUNDS; c++) begin : g_cell
    brsc_cell #(
      .NCELL    (MAX_ROUNDS),
      .CELL_IDX (c)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .req_i (chain_req[c]),
      .key_i (chain_key[c]),
      .act_i (chain_act[c]),
      .req_o (chain_req[c+1]),
      .key_o (chain_key[c+1]),
      .act_o (chain_act[c+1])
    );
  end

  brsc_fifo #(
    .DEPTH (OQ_DEPTH)
  ) u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (chain_req[MAX_ROUNDS].ciph),
    .wr_data   (chain_req[MAX_ROUNDS].k),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_byte)
  );

  `BRSC_ASSERT_IMP(a_crd_bound, clk, rst_n, 1'b1, crd_r <= CRD_W'(OQ_DEPTH))
  `BRSC_ASSERT_IMP(a_out_has_crd, clk, rst_n, out_valid, crd_r != '0)
  `BRSC_ASSERT_IMP(a_tail_has_crd, clk, rst_n, chain_req[MAX_ROUNDS].ciph, crd_r != '0)
  `BRSC_ASSERT_NXT(a_crd_inc, clk, rst_n, crd_inc && !crd_dec, crd_r == $past(crd_r) + 1'b1)

endmodule
